/* hdl/energy_counter_accumulator_unit_macros.svh */
// Assertion macros shared by the checker of the energy counter accumulator.
// No dependencies; include by bare file name.
`ifndef ENERGY_COUNTER_ACCUMULATOR_UNIT_MACROS_SVH
`define ENERGY_COUNTER_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ECAU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecau check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ECAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ecau check failed");

`endif

/* hdl/ecau_pkg.sv */
// Shared types and constants for the energy counter accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ecau_pkg;

   localparam int READING_W   = 48;
   localparam int WORD_W      = 32;
   localparam int TOTAL_W     = 64;
   localparam int WIN_E_W     = 51;
   localparam int WIN_T_W     = 35;
   localparam int WIN_CNT_W   = 3;
   localparam int IDLE_WINDOW = 5;

   localparam int MW_SCALE_W = 10;
   localparam int PRODUCT_W  = WIN_E_W + MW_SCALE_W;
   localparam int DIV_STEP_W = $clog2(PRODUCT_W + 1);

   localparam logic [MW_SCALE_W-1:0] MW_SCALE      = 10'd1000;
   localparam logic [WORD_W-1:0]     ONE_SECOND_US = 32'd1000000;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;

   // register index, taken from paddr[3]
   localparam logic CSR_IDX_WRAP  = 1'b0;
   localparam logic CSR_IDX_START = 1'b1;

   typedef enum logic [1:0] {
      CAL_PENDING = 2'd0,
      CAL_IDLE    = 2'd1,
      CAL_LOADED  = 2'd2
   } cal_type;

   typedef struct packed {
      logic [READING_W-1:0] reading;
      logic [WORD_W-1:0]    elapsed_us;
      logic [WORD_W-1:0]    requests_now;
   } req_type;

   typedef struct packed {
      logic [READING_W-1:0] delta_uj;
      logic [TOTAL_W-1:0]   total_uj;
      logic [1:0]           cal_status;
      logic [WORD_W-1:0]    idle_mw;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic calc_delta;
      logic accum;
      logic mult;
      logic div_start;
      logic set_idle;
      logic set_loaded;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic primed;
      logic cal_pending;
      logic window_end;
      logic quiet;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

/* hdl/ecau_div.sv */
// Restoring divider, one quotient bit per cycle, for the idle power figure.
// Depends on ecau_pkg.
`default_nettype none

module ecau_div import ecau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PRODUCT_W-1:0] dividend,
   input  logic [WIN_T_W-1:0]   divisor,
   output logic                 done,
   output logic [PRODUCT_W-1:0] quotient
);

   logic [PRODUCT_W-1:0]  dvd_ff, dvd_in;
   logic [WIN_T_W-1:0]    rem_ff, rem_in;
   logic [WIN_T_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_STEP_W-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [WIN_T_W:0] trial;
   logic [WIN_T_W:0] diff;
   logic             fits;

   assign trial = {rem_ff, dvd_ff[PRODUCT_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         dvd_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = DIV_STEP_W'(PRODUCT_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // quotient bits shift in behind the dividend bits
         dvd_in   = {dvd_ff[PRODUCT_W-2:0], fits};
         rem_in   = fits ? diff[WIN_T_W-1:0] : trial[WIN_T_W-1:0];
         count_in = count_ff - DIV_STEP_W'(1);
         if (count_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

/* hdl/ecau_ctrl.sv */
// Sequencer of the energy counter accumulator: walks one item through delta,
// accumulate, window check, multiply, divide and result load. Depends on ecau_pkg.
`default_nettype none

module ecau_ctrl import ecau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DELTA = 7'b0000010,
      S_ACCUM = 7'b0000100,
      S_CHECK = 7'b0001000,
      S_MULT  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.calc_delta = 1'b1;
            state_in       = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = (sts.primed && sts.cal_pending) ? S_CHECK : S_EMIT;
         end
         S_CHECK: begin
            if (!sts.window_end) begin
               state_in = S_EMIT;
            end else if (sts.quiet) begin
               cmd.mult = 1'b1;
               state_in = S_MULT;
            end else begin
               cmd.set_loaded = 1'b1;
               state_in       = S_EMIT;
            end
         end
         S_MULT: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.set_idle = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ecau_dpath.sv */
// Datapath of the energy counter accumulator: item register, delta, totals,
// calibration window, divider and result register. Depends on ecau_pkg, ecau_div.
`default_nettype none

module ecau_dpath import ecau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  req_type              req_data,
   input  logic [READING_W-1:0] wrap_range,
   input  logic [WORD_W-1:0]    start_requests,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   req_type               item_ff;
   logic [READING_W-1:0]  delta_ff, delta_in;
   logic [READING_W-1:0]  last_ff, last_in;
   logic                  primed_ff, primed_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [WIN_E_W-1:0]    win_e_ff, win_e_in;
   logic [WIN_T_W-1:0]    win_t_ff, win_t_in;
   logic [WIN_CNT_W-1:0]  win_cnt_ff, win_cnt_in;
   cal_type               cal_ff, cal_in;
   logic [WORD_W-1:0]     idle_pw_ff, idle_pw_in;
   logic [PRODUCT_W-1:0]  product_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   logic [READING_W-1:0]  cur;
   logic [READING_W-1:0]  raw_delta;
   logic [WORD_W-1:0]     elapsed_eff;
   logic                  div_done;
   logic [PRODUCT_W-1:0]  quotient;
   logic [WORD_W-1:0]     quotient_sat;

   assign cur = item_ff.reading;

   // wrap-aware difference; with no range the counter restarts from zero
   always_comb begin
      if (cur >= last_ff) begin
         raw_delta = cur - last_ff;
      end else if (wrap_range != '0) begin
         raw_delta = (wrap_range - last_ff) + cur;
      end else begin
         raw_delta = cur;
      end
   end

   assign elapsed_eff = (item_ff.elapsed_us == '0) ? ONE_SECOND_US : item_ff.elapsed_us;

   assign quotient_sat = (quotient[PRODUCT_W-1:WORD_W] != '0) ? '1 : quotient[WORD_W-1:0];

   ecau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (product_ff),
      .divisor  (win_t_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      delta_in   = delta_ff;
      last_in    = last_ff;
      primed_in  = primed_ff;
      total_in   = total_ff;
      win_e_in   = win_e_ff;
      win_t_in   = win_t_ff;
      win_cnt_in = win_cnt_ff;
      cal_in     = cal_ff;
      idle_pw_in = idle_pw_ff;
      if (cmd.calc_delta) begin
         delta_in = primed_ff ? raw_delta : '0;
      end
      if (cmd.accum) begin
         last_in   = cur;
         primed_in = 1'b1;
         if (primed_ff) begin
            total_in = total_ff + TOTAL_W'(delta_ff);
            if (cal_ff == CAL_PENDING) begin
               win_e_in   = win_e_ff + WIN_E_W'(delta_ff);
               win_t_in   = win_t_ff + WIN_T_W'(elapsed_eff);
               win_cnt_in = win_cnt_ff + WIN_CNT_W'(1);
            end
         end
      end
      if (cmd.set_loaded) begin
         idle_pw_in = '0;
         cal_in     = CAL_LOADED;
      end
      if (cmd.set_idle) begin
         idle_pw_in = quotient_sat;
         cal_in     = CAL_IDLE;
      end
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         primed_ff    <= 1'b0;
         total_ff     <= '0;
         win_e_ff     <= '0;
         win_t_ff     <= '0;
         win_cnt_ff   <= '0;
         cal_ff       <= CAL_PENDING;
         idle_pw_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         primed_ff    <= primed_in;
         total_ff     <= total_in;
         win_e_ff     <= win_e_in;
         win_t_ff     <= win_t_in;
         win_cnt_ff   <= win_cnt_in;
         cal_ff       <= cal_in;
         idle_pw_ff   <= idle_pw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      delta_ff <= delta_in;
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.mult) begin
         product_ff <= PRODUCT_W'(win_e_ff) * PRODUCT_W'(MW_SCALE);
      end
      if (cmd.emit) begin
         rsp_data_ff.delta_uj   <= delta_ff;
         rsp_data_ff.total_uj   <= total_ff;
         rsp_data_ff.cal_status <= cal_ff;
         rsp_data_ff.idle_mw    <= (cal_ff == CAL_IDLE) ? idle_pw_ff : '0;
      end
   end

   assign sts.primed      = primed_ff;
   assign sts.cal_pending = (cal_ff == CAL_PENDING);
   assign sts.window_end  = (win_cnt_ff >= WIN_CNT_W'(IDLE_WINDOW));
   assign sts.quiet       = (item_ff.requests_now == start_requests) && (win_t_ff != '0);
   assign sts.div_done    = div_done;
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/energy_counter_accumulator_unit.sv */
// Energy counter accumulator. An item is accepted when req_ready is high, which
// is the case whenever no item is in flight, even while the previous result
// still waits in the output register. Each item runs through capture, delta,
// accumulate, a window check while calibration is pending on a primed item,
// and emit, which waits while the previous result is still held off by
// rsp_ready; the item that closes the idle window and finds no new requests runs
// a multiply, then the restoring divider over 61 bits, one quotient bit per cycle.
// Registers: wrap_range at byte address 0x0, start_requests at 0x8.
// Depends on ecau_pkg, ecau_ctrl, ecau_dpath.
`default_nettype none

module energy_counter_accumulator_unit import ecau_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [READING_W-1:0] wrap_range_ff, wrap_range_in;
   logic [WORD_W-1:0]    start_req_ff, start_req_in;
   logic                 csr_write;
   logic                 csr_idx;
   cmd_type              cmd;
   sts_type              sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3];

   always_comb begin
      wrap_range_in = wrap_range_ff;
      start_req_in  = start_req_ff;
      if (csr_write) begin
         case (csr_idx)
            CSR_IDX_WRAP:  wrap_range_in = csr_pwdata[READING_W-1:0];
            CSR_IDX_START: start_req_in  = csr_pwdata[WORD_W-1:0];
            default:       wrap_range_in = wrap_range_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IDX_WRAP:  csr_prdata = CSR_DATA_W'(wrap_range_ff);
         CSR_IDX_START: csr_prdata = CSR_DATA_W'(start_req_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_range_ff <= '0;
         start_req_ff  <= '0;
      end else begin
         wrap_range_ff <= wrap_range_in;
         start_req_ff  <= start_req_in;
      end
   end

   ecau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ecau_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_data       (req_data),
      .wrap_range     (wrap_range_ff),
      .start_requests (start_req_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire

/* hdl/ecau_checker.sv */
// Port-level checks for the energy counter accumulator, bound to the top level.
// Depends on ecau_pkg and energy_counter_accumulator_unit_macros.svh.
`default_nettype none
`include "energy_counter_accumulator_unit_macros.svh"

module ecau_checker import ecau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // one item at a time: taking an item closes the input until its result is loaded
   `ECAU_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // a power figure only ever shows with the calibrated status
   `ECAU_ASSERT_NOW(a_mw_only_calibrated, clock, reset,
      rsp_valid && (rsp_data.idle_mw != '0), rsp_data.cal_status == CAL_IDLE)

   // a stalled result holds
   `ECAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

endmodule

bind energy_counter_accumulator_unit ecau_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
